[design/sdiv_pkg.sv]
// Shared types and constants for the signed saturating divider.
// No dependencies; used by every module of the block.
`default_nettype none

package sdiv_pkg;

  // Default operand and quotient width
  localparam int unsigned DATA_WIDTH_DEF = 32;

  // Control that travels with each item down the chain
  typedef struct packed {
    logic valid;  // stage holds a live item
    logic sat;    // quotient saturates to the largest positive value
    logic neg;    // operand signs differ, quotient is negated at the end
  } sdiv_ctl_t;

endpackage : sdiv_pkg

`default_nettype wire

[design/signed_divider_saturating_unit.sv]
// Top level of the signed saturating divider: entry stage, cell chain, exit stage.
// Depends on sdiv_pkg, sdiv_prep, sdiv_cell and sdiv_fix.
`default_nettype none

// Signed divider, quotient truncated toward zero. A zero divisor, and the most
// negative dividend over minus one, give the largest positive value. An item
// is taken at every clock edge with start high (busy is always low). Its
// quotient is on out_quotient, with out_valid high, for a single cycle once
// it has passed the registers of one entry stage, a chain of DATA_WIDTH
// restoring cells, one quotient bit each, and one exit stage. Items leave in
// the order they entered, one per cycle at most. The receiver cannot stall
// the output, so a result must be taken in its strobe cycle.
module signed_divider_saturating_unit #(
  parameter int unsigned DATA_WIDTH = sdiv_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [DATA_WIDTH-1:0] in_numerator,
  input  wire logic [DATA_WIDTH-1:0] in_denominator,
  output logic                       out_valid,
  output logic      [DATA_WIDTH-1:0] out_quotient
);
  import sdiv_pkg::*;

  // Stage links: index 0 is the entry stage output, DATA_WIDTH the last cell
  sdiv_ctl_t             ctl_s [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0] rem_s [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0] num_s [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0] den_s [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0] quo_s [DATA_WIDTH+1];
  logic                  accept;

  // Fully pipelined, never holds items off
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  sdiv_prep #(.DATA_WIDTH(DATA_WIDTH)) u_prep (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .numerator   (in_numerator),
    .denominator (in_denominator),
    .ctl_o       (ctl_s[0]),
    .num_mag_o   (num_s[0]),
    .den_mag_o   (den_s[0])
  );

  // Partial remainder and quotient start empty
  assign rem_s[0] = '0;
  assign quo_s[0] = '0;

  // One cell per quotient bit
  for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
    sdiv_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl_i (ctl_s[i]),
      .rem_i (rem_s[i]),
      .num_i (num_s[i]),
      .den_i (den_s[i]),
      .quo_i (quo_s[i]),
      .ctl_o (ctl_s[i+1]),
      .rem_o (rem_s[i+1]),
      .num_o (num_s[i+1]),
      .den_o (den_s[i+1]),
      .quo_o (quo_s[i+1])
    );
  end

  sdiv_fix #(.DATA_WIDTH(DATA_WIDTH)) u_fix (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl_i      (ctl_s[DATA_WIDTH]),
    .quo_i      (quo_s[DATA_WIDTH]),
    .valid_o    (out_valid),
    .quotient_o (out_quotient)
  );

endmodule : signed_divider_saturating_unit

`default_nettype wire

[design/sdiv_prep.sv]
// Entry stage: magnitudes, quotient sign and saturation flag, registered.
// Depends on sdiv_pkg.
`default_nettype none

module sdiv_prep #(
  parameter int unsigned DATA_WIDTH = sdiv_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  accept,
  input  wire logic [DATA_WIDTH-1:0] numerator,
  input  wire logic [DATA_WIDTH-1:0] denominator,
  output sdiv_pkg::sdiv_ctl_t        ctl_o,
  output logic      [DATA_WIDTH-1:0] num_mag_o,
  output logic      [DATA_WIDTH-1:0] den_mag_o
);
  import sdiv_pkg::*;

  localparam logic [DATA_WIDTH-1:0] MOST_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic [DATA_WIDTH-1:0] MINUS_ONE = {DATA_WIDTH{1'b1}};

  sdiv_ctl_t             ctl_r, ctl_nxt;
  logic [DATA_WIDTH-1:0] num_mag_r, num_mag_nxt;
  logic [DATA_WIDTH-1:0] den_mag_r, den_mag_nxt;

  // Special cases and magnitudes; the most negative value keeps its bit pattern,
  // which is its correct unsigned magnitude
  always_comb begin
    ctl_nxt.valid = accept;
    ctl_nxt.sat   = (denominator == '0) ||
                    ((numerator == MOST_NEG) && (denominator == MINUS_ONE));
    ctl_nxt.neg   = numerator[DATA_WIDTH-1] ^ denominator[DATA_WIDTH-1];
    num_mag_nxt   = numerator[DATA_WIDTH-1] ? (~numerator + 1'b1) : numerator;
    den_mag_nxt   = denominator[DATA_WIDTH-1] ? (~denominator + 1'b1) : denominator;
  end

  // Control register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    num_mag_r <= num_mag_nxt;
    den_mag_r <= den_mag_nxt;
  end

  assign ctl_o     = ctl_r;
  assign num_mag_o = num_mag_r;
  assign den_mag_o = den_mag_r;

endmodule : sdiv_prep

`default_nettype wire

[design/sdiv_cell.sv]
// One restoring division step: produces one quotient bit, MSB first, registered.
// Depends on sdiv_pkg.
`default_nettype none

module sdiv_cell #(
  parameter int unsigned DATA_WIDTH = sdiv_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  sdiv_pkg::sdiv_ctl_t        ctl_i,
  input  wire logic [DATA_WIDTH-1:0] rem_i,
  input  wire logic [DATA_WIDTH-1:0] num_i,
  input  wire logic [DATA_WIDTH-1:0] den_i,
  input  wire logic [DATA_WIDTH-1:0] quo_i,
  output sdiv_pkg::sdiv_ctl_t        ctl_o,
  output logic      [DATA_WIDTH-1:0] rem_o,
  output logic      [DATA_WIDTH-1:0] num_o,
  output logic      [DATA_WIDTH-1:0] den_o,
  output logic      [DATA_WIDTH-1:0] quo_o
);
  import sdiv_pkg::*;

  sdiv_ctl_t             ctl_r;
  logic [DATA_WIDTH-1:0] rem_r, rem_nxt;
  logic [DATA_WIDTH-1:0] num_r, num_nxt;
  logic [DATA_WIDTH-1:0] den_r;
  logic [DATA_WIDTH-1:0] quo_r, quo_nxt;
  logic [DATA_WIDTH-1:0] trial;
  logic                  fits;

  // Bring down the next dividend bit and try the subtraction; the partial
  // remainder stays below the divisor, so the shifted value fits the width
  always_comb begin
    trial   = {rem_i[DATA_WIDTH-2:0], num_i[DATA_WIDTH-1]};
    fits    = (trial >= den_i);
    rem_nxt = fits ? (trial - den_i) : trial;
    num_nxt = {num_i[DATA_WIDTH-2:0], 1'b0};
    quo_nxt = {quo_i[DATA_WIDTH-2:0], fits};
  end

  // Control register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_i;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    num_r <= num_nxt;
    den_r <= den_i;
    quo_r <= quo_nxt;
  end

  assign ctl_o = ctl_r;
  assign rem_o = rem_r;
  assign num_o = num_r;
  assign den_o = den_r;
  assign quo_o = quo_r;

endmodule : sdiv_cell

`default_nettype wire

[design/sdiv_fix.sv]
// Exit stage: sign fix-up, saturation and the registered result strobe.
// Depends on sdiv_pkg.
`default_nettype none

module sdiv_fix #(
  parameter int unsigned DATA_WIDTH = sdiv_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  sdiv_pkg::sdiv_ctl_t        ctl_i,
  input  wire logic [DATA_WIDTH-1:0] quo_i,
  output logic                       valid_o,
  output logic      [DATA_WIDTH-1:0] quotient_o
);
  import sdiv_pkg::*;

  localparam logic [DATA_WIDTH-1:0] MAX_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};

  logic                  valid_r;
  logic [DATA_WIDTH-1:0] quotient_r, quotient_nxt;

  // Saturate, else negate when the operand signs differ
  always_comb begin
    if (ctl_i.sat) begin
      quotient_nxt = MAX_POS;
    end else if (ctl_i.neg) begin
      quotient_nxt = ~quo_i + 1'b1;
    end else begin
      quotient_nxt = quo_i;
    end
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= ctl_i.valid;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    quotient_r <= quotient_nxt;
  end

  assign valid_o    = valid_r;
  assign quotient_o = quotient_r;

endmodule : sdiv_fix

`default_nettype wire

[design/sdiv_checker.sv]
// Port-level checks for the signed saturating divider, bound to the top level.
// Depends on sdiv_pkg and signed_divider_saturating_unit.
`default_nettype none

module sdiv_checker #(
  parameter int unsigned DATA_WIDTH = sdiv_pkg::DATA_WIDTH_DEF
) (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  start,
  input wire logic                  busy,
  input wire logic [DATA_WIDTH-1:0] in_numerator,
  input wire logic [DATA_WIDTH-1:0] in_denominator,
  input wire logic                  out_valid,
  input wire logic [DATA_WIDTH-1:0] out_quotient
);

  localparam int unsigned LATENCY = DATA_WIDTH + 2;
  localparam logic [DATA_WIDTH-1:0] MAX_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] ONE = {{(DATA_WIDTH-1){1'b0}}, 1'b1};

  // Every accepted item yields a result strobe
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("accepted item gave no result");

  // No result without an item accepted at the matching edge
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result strobe without an accepted item");

  // Zero divisor saturates
  a_zero_div: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_denominator == '0) |-> ##LATENCY (out_quotient == MAX_POS))
    else $error("zero divisor did not saturate");

  // Division by one passes the dividend through
  a_div_one: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_denominator == ONE)
      |-> ##LATENCY (out_quotient == $past(in_numerator, LATENCY)))
    else $error("division by one changed the dividend");

endmodule : sdiv_checker

bind signed_divider_saturating_unit sdiv_checker #(.DATA_WIDTH(DATA_WIDTH)) u_sdiv_checker (.*);

`default_nettype wire
